@@ hdl/garp_pkg.sv @@
// shared types and constants for the glyph atlas row packer
// no dependencies
`timescale 1ns / 1ps
package garp_pkg;
	localparam int MAX_ROW_GLYPHS = 512;
	localparam int IDX_W = $clog2(MAX_ROW_GLYPHS);
	localparam int CNT_W = $clog2(MAX_ROW_GLYPHS + 1);
	localparam int SEG_W = 48;

	localparam logic [1:0] REG_ATLAS_WIDTH  = 2'd0;
	localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GAP          = 2'd2;

	localparam logic ACT_RESET = 1'b0;
	localparam logic ACT_PLACE = 1'b1;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] stop;
		logic [15:0] bottom;
	} seg_t;
endpackage

@@ hdl/garp_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module garp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/glyph_atlas_row_packer.sv @@
// glyph atlas row packer: places glyphs into texture pages row by row
// a placement passes IDLE and CHECK, then RD and SCAN per previous-row segment scanned (RD
// alone when none), then FIN and PUT; each segment is read from the registered row memory read port, then compared
// throughput: one transaction at a time; a placement holds in its last state while a
// result waits; skips end in CHECK, reset actions in IDLE; reset: arst_n clears control
// state, row memories stay undefined until written; depends on garp_pkg and garp_ram
`timescale 1ns / 1ps
module glyph_atlas_row_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [9:0]  glyph_width,
	input  logic [9:0]  glyph_height,
	input  logic [20:0] glyph_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] x_position,
	output logic [15:0] y_position,
	output logic [15:0] page_number,
	output logic [20:0] code_out
);
	import garp_pkg::*;

	typedef enum logic [2:0] {IDLE, CHECK, RD, SCAN, FIN, PUT} state_t;
	state_t state_q;

	logic [15:0] aw_q, ah_q;
	logic [7:0]  gap_q;
	logic        sel_q;        // bank holding previous row
	logic        prev_full_q;  // previous row is the synthetic full segment
	logic [15:0] full_stop_q;  // full segment end, captured at restart
	logic [7:0]  full_gap_q;   // full segment bottom, captured at restart
	logic [CNT_W-1:0] prev_cnt_q, cur_cnt_q, idx_q;
	logic [15:0] left_q, page_q;
	logic [9:0]  w_q, h_q;
	logic [20:0] code_q;
	logic [17:0] lo_q, hi_q;
	logic [15:0] top_q;
	logic        inside_q;

	// row memories: one holds previous row, other current row
	logic        we_a, we_b;
	logic [IDX_W-1:0] raddr;
	logic [SEG_W-1:0] wdata, rd_a, rd_b;
	seg_t        rseg;

	garp_ram #(.WIDTH(SEG_W), .DEPTH(MAX_ROW_GLYPHS)) u_bank_a (
		.clk(clk), .we(we_a), .waddr(cur_cnt_q[IDX_W-1:0]), .wdata(wdata),
		.raddr(raddr), .rdata(rd_a));
	garp_ram #(.WIDTH(SEG_W), .DEPTH(MAX_ROW_GLYPHS)) u_bank_b (
		.clk(clk), .we(we_b), .waddr(cur_cnt_q[IDX_W-1:0]), .wdata(wdata),
		.raddr(raddr), .rdata(rd_b));

	assign raddr = idx_q[IDX_W-1:0];
	assign rseg  = sel_q ? seg_t'(rd_b) : seg_t'(rd_a);
	assign in_ready = (state_q == IDLE);

	// wide sums for checks
	logic [17:0] gap2, right_w;
	logic [17:0] bottom_w;
	assign gap2 = {9'd0, gap_q, 1'b0};
	assign right_w = {2'd0, left_q} + {8'd0, w_q} + {10'd0, gap_q};
	assign bottom_w = {2'd0, top_q} + {8'd0, h_q} + {10'd0, gap_q};

	// synthetic full segment when prev row was restarted
	seg_t cur_seg;
	always_comb begin
		if (prev_full_q) begin
			cur_seg.start  = 16'd0;
			cur_seg.stop   = full_stop_q;
			cur_seg.bottom = {8'd0, full_gap_q};
		end else begin
			cur_seg = rseg;
		end
	end

	logic lo_in, hi_in, ins;
	assign lo_in = (lo_q >= {2'd0, cur_seg.start}) && (lo_q <= {2'd0, cur_seg.stop});
	assign hi_in = (hi_q >= {2'd0, cur_seg.start}) && (hi_q <= {2'd0, cur_seg.stop});
	assign ins   = inside_q || lo_in;

	// result register loads when empty or being drained
	logic put_fire;
	assign put_fire = (state_q == PUT) && (!out_valid || out_ready);

	// segment write happens in PUT with final top and bottom
	logic do_wr;
	assign do_wr = put_fire && (cur_cnt_q < CNT_W'(MAX_ROW_GLYPHS));
	assign we_a = do_wr && sel_q;
	assign we_b = do_wr && !sel_q;
	assign wdata = {lo_q[15:0], hi_q[15:0], bottom_w[15:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			aw_q <= 16'd512; ah_q <= 16'd512; gap_q <= 8'd1;
			sel_q <= 1'b0; prev_full_q <= 1'b1;
			full_stop_q <= 16'd512; full_gap_q <= 8'd1;
			prev_cnt_q <= CNT_W'(1); cur_cnt_q <= '0; idx_q <= '0;
			left_q <= 16'd1; page_q <= '0;
			out_valid <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ATLAS_WIDTH:  aw_q <= cfg_data;
					REG_ATLAS_HEIGHT: ah_q <= cfg_data;
					REG_GAP:          gap_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (put_fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				IDLE: if (in_valid) begin
					w_q <= glyph_width; h_q <= glyph_height; code_q <= glyph_code;
					if (action == ACT_RESET) begin
						left_q <= {8'd0, gap_q}; page_q <= '0;
						prev_full_q <= 1'b1; prev_cnt_q <= CNT_W'(1); cur_cnt_q <= '0;
						full_stop_q <= aw_q; full_gap_q <= gap_q;
					end else begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					if (({8'd0, w_q} + gap2 > {2'd0, aw_q}) ||
					    ({8'd0, h_q} + gap2 > {2'd0, ah_q})) begin
						state_q <= IDLE;
					end else begin
						if (right_w > {2'd0, aw_q}) begin
							// row wrap: current row becomes previous
							lo_q <= {10'd0, gap_q};
							hi_q <= {10'd0, gap_q} + {8'd0, w_q} + {10'd0, gap_q};
							sel_q <= ~sel_q; prev_full_q <= 1'b0;
							prev_cnt_q <= cur_cnt_q; cur_cnt_q <= '0;
						end else begin
							lo_q <= {2'd0, left_q}; hi_q <= right_w;
						end
						top_q <= '0; inside_q <= 1'b0; idx_q <= '0;
						state_q <= RD;
					end
				end
				RD: state_q <= (prev_cnt_q == '0) ? FIN : SCAN;  // read issued
				SCAN: begin
					inside_q <= ins;
					if (ins && cur_seg.bottom > top_q) top_q <= cur_seg.bottom;
					if (hi_in || (idx_q + CNT_W'(1) >= prev_cnt_q)) state_q <= FIN;
					else begin
						idx_q <= idx_q + CNT_W'(1);
						state_q <= RD;
					end
				end
				FIN: begin
					if (bottom_w > {2'd0, ah_q}) begin
						// page overflow: restart rows, keep left cursor
						if (page_q != 16'hFFFF) page_q <= page_q + 16'd1;
						prev_full_q <= 1'b1; prev_cnt_q <= CNT_W'(1);
						full_stop_q <= aw_q; full_gap_q <= gap_q;
						cur_cnt_q <= '0;
						top_q <= {8'd0, gap_q};
					end
					state_q <= PUT;
				end
				PUT: begin
					if (put_fire) begin
						// record segment now that top is final
						x_position <= lo_q[15:0]; y_position <= top_q;
						page_number <= page_q; code_out <= code_q;
						left_q <= hi_q[15:0];
						if (cur_cnt_q < CNT_W'(MAX_ROW_GLYPHS))
							cur_cnt_q <= cur_cnt_q + CNT_W'(1);
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PUT && (!out_valid || out_ready)) |=> out_valid)
		else $error("result not raised");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == IDLE))
		else $error("ready outside idle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_cnt_q <= CNT_W'(MAX_ROW_GLYPHS))
		else $error("row count overflow");
endmodule
